FILE: rtl/core/signed_restoring_divider_macros.svh
// ----------------------------------------------------------------------------
// Signed restoring divider assertion macros
// Shared property wrappers for the divider checker; clock clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RESTORING_DIVIDER_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_MACROS_SVH

// Same-cycle implication.
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Widths, types and helpers shared by the signed restoring divider.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam word_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t DATA_ONES = {DATA_WIDTH{1'b1}};

  // result of one restoring step
  typedef struct packed {
    logic  qbit;
    word_t rem;
  } step_t;

  function automatic word_t negate(word_t v);
    return word_t'(~v + word_t'(1));
  endfunction

  function automatic word_t magnitude(word_t v);
    return v[DATA_WIDTH-1] ? negate(v) : v;
  endfunction

endpackage

FILE: rtl/core/srd_step.sv
// ----------------------------------------------------------------------------
// srd_step
// One restoring step: shift in a dividend bit, trial subtract, keep or restore.
// ----------------------------------------------------------------------------
module srd_step (
  input  srd_pkg::word_t rem,
  input  logic           din,
  input  srd_pkg::word_t dvsr,
  output srd_pkg::step_t res
);

  logic [srd_pkg::DATA_WIDTH:0] trial;
  logic [srd_pkg::DATA_WIDTH:0] diff;
  logic                         fits;

  always_comb begin
    trial = {rem, din};
    diff  = trial - {1'b0, dvsr};
    fits  = !diff[srd_pkg::DATA_WIDTH];  // no borrow: trial >= divisor
    res.qbit = fits;
    // partial remainder stays below the divisor magnitude, so it fits a word
    res.rem  = fits ? diff[srd_pkg::DATA_WIDTH-1:0] : trial[srd_pkg::DATA_WIDTH-1:0];
  end

endmodule

FILE: rtl/core/signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// signed_restoring_divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat fields
//  --------+-----------+--------------------+------------------------------------
//  op      | in        | op_valid/op_stall  | dividend, divisor
//  res     | out       | res_valid/res_stall| quotient, remainder,
//          |           |                    | divide_by_zero, overflow
//
//  An op beat is loaded, then takes 32 steps through the single
//  subtract/compare unit (srd_step), then a sign fix-up into the result regs.
//  op_stall is high from load until the fix-up writes the result register.
//  A new op is taken while the previous result still waits on res_stall;
//  the fix-up cycle holds until the result register is free.
//  Synchronous active-high rst clears the sequencer and res_valid only.
// ----------------------------------------------------------------------------
module signed_restoring_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op_valid,
  output logic                                op_stall,
  input  logic signed [srd_pkg::DATA_WIDTH-1:0] dividend,
  input  logic signed [srd_pkg::DATA_WIDTH-1:0] divisor,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [srd_pkg::DATA_WIDTH-1:0] quotient,
  output logic signed [srd_pkg::DATA_WIDTH-1:0] remainder,
  output logic                                divide_by_zero,
  output logic                                overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

  state_t         state;
  srd_pkg::cnt_t  cnt;      // steps left minus one, counts down to zero
  srd_pkg::word_t acc;      // A: partial remainder
  srd_pkg::word_t quo;      // Q: dividend bits out at top, quotient bits in at bottom
  srd_pkg::word_t dvsr;     // M: divisor magnitude
  logic           neg_a;
  logic           neg_b;
  logic           dz;
  logic           ovf;
  srd_pkg::step_t step;

  // shared step unit; next dividend bit is the top of Q
  srd_step u_step (
    .rem  (acc),
    .din  (quo[srd_pkg::DATA_WIDTH-1]),
    .dvsr (dvsr),
    .res  (step)
  );

  assign op_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // in fix-up the result register is refilled instead
      if (res_valid && !res_stall && state != ST_FIX) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (op_valid) begin
          // load: work on magnitudes, remember signs and special cases
          acc   <= '0;
          quo   <= srd_pkg::magnitude(srd_pkg::word_t'(dividend));
          dvsr  <= srd_pkg::magnitude(srd_pkg::word_t'(divisor));
          neg_a <= dividend[srd_pkg::DATA_WIDTH-1];
          neg_b <= divisor[srd_pkg::DATA_WIDTH-1];
          dz    <= (srd_pkg::word_t'(divisor) == '0);
          ovf   <= (srd_pkg::word_t'(dividend) == srd_pkg::DATA_MIN) &&
                   (srd_pkg::word_t'(divisor) == srd_pkg::DATA_ONES);
          cnt   <= srd_pkg::cnt_t'(srd_pkg::DATA_WIDTH - 1);
          state <= ST_RUN;
        end
        ST_RUN: begin
          acc <= step.rem;
          quo <= {quo[srd_pkg::DATA_WIDTH-2:0], step.qbit};
          cnt <= cnt - srd_pkg::cnt_t'(1);
          if (cnt == '0) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: if (!res_valid || !res_stall) begin
          // sign fix-up; min / -1 wraps on its own, as the magnitude of min is min
          if (dz) begin
            quotient  <= '0;
            remainder <= '0;
          end else begin
            quotient  <= (neg_a ^ neg_b) ? srd_pkg::negate(quo) : quo;
            remainder <= neg_a ? srd_pkg::negate(acc) : acc;
          end
          divide_by_zero <= dz;
          overflow       <= ovf;
          res_valid      <= 1'b1;
          state          <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/srd_checker.sv
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks for the signed restoring divider, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_restoring_divider_macros.svh"

module srd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          op_valid,
  input logic                          op_stall,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic [srd_pkg::DATA_WIDTH-1:0] quotient,
  input logic [srd_pkg::DATA_WIDTH-1:0] remainder,
  input logic                          divide_by_zero,
  input logic                          overflow
);

  logic op_acc;
  assign op_acc = op_valid && !op_stall;

  // a taken op keeps the unit busy on the next cycle
  `SRD_ASSERT_NEXT(a_busy_after_op, op_acc, op_stall, "divider took op back to back")

  // divide by zero gives zero results and no overflow
  `SRD_ASSERT_NOW(a_dz_result, res_valid && divide_by_zero,
    quotient == '0 && remainder == '0 && !overflow, "bad divide-by-zero beat")

  // overflow only for min / -1: quotient wraps to min, remainder zero
  `SRD_ASSERT_NOW(a_ovf_result, res_valid && overflow,
    quotient == srd_pkg::DATA_MIN && remainder == '0, "bad overflow beat")

  // stalled result beat holds
  `SRD_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(quotient) && $stable(remainder), "result beat changed under stall")

endmodule

bind signed_restoring_divider srd_checker u_srd_checker (
  .clk            (clk),
  .rst            (rst),
  .op_valid       (op_valid),
  .op_stall       (op_stall),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .quotient       (quotient),
  .remainder      (remainder),
  .divide_by_zero (divide_by_zero),
  .overflow       (overflow)
);
